### rtl/lspf_pkg.sv
// Shared types, constants and the solve microprogram for the plane fit unit.
package lspf_pkg;

	localparam int MAX_POINTS = 5;
	localparam int PTS_W      = $clog2(MAX_POINTS + 1);
	localparam int COORD_W    = 24;
	localparam int MOM_W      = 53;
	localparam int SUM_W      = 31;
	localparam int PROD_W     = 2 * COORD_W;
	localparam int CO_W       = 108;
	localparam int WIDE_W     = 192;
	localparam int COEF_W     = 64;
	localparam int NORM_W     = 63;
	localparam int SQ_W       = 128;
	localparam int STEP_W     = 8;
	localparam int MUL_STEPS  = 64;
	localparam int DIV_STEPS  = 192;
	localparam int SQRT_STEPS = 64;
	localparam int ACC_STEPS  = 7;
	localparam int FRAC_SHIFT = 48;
	localparam int PC_W       = 5;
	localparam logic [WIDE_W-1:0] DET_LIMIT = WIDE_W'(64'd28147497672);
	localparam logic [COEF_W-1:0] COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] x_pos;
		logic signed [COORD_W-1:0] y_pos;
		logic signed [COORD_W-1:0] z_pos;
		logic                      last_point;
	} point_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_a;
		logic signed [COEF_W-1:0] coef_b;
		logic signed [COEF_W-1:0] coef_c;
		logic [NORM_W-1:0]        plane_norm;
		logic                     singular;
	} result_t;

	// Operands of the shared multiply-accumulate
	typedef enum logic [4:0] {
		OPND_M0, OPND_M1, OPND_M2, OPND_M3, OPND_M4, OPND_M5,
		OPND_C00, OPND_C01, OPND_C02, OPND_C11, OPND_C12, OPND_C22,
		OPND_S0, OPND_S1, OPND_S2,
		OPND_CA, OPND_CB, OPND_CC
	} opnd_t;

	// Where a finished accumulation goes
	typedef enum logic [3:0] {
		DST_NONE, DST_C00, DST_C01, DST_C02, DST_C11, DST_C12, DST_C22,
		DST_DET, DST_NUM, DST_SUMSQ
	} dst_t;

	typedef struct packed {
		opnd_t a_sel;
		opnd_t b_sel;
		logic  clr;
		logic  neg;
		dst_t  dst;
	} mac_op_t;

	// Solve microprogram: cofactors, determinant, three numerators, sum of squares
	function automatic mac_op_t prog_op(input logic [PC_W-1:0] pc);
		mac_op_t op;
		op = '{OPND_M0, OPND_M0, 1'b0, 1'b0, DST_NONE};
		case (pc)
			5'd0:  op = '{OPND_M3,  OPND_M5, 1'b1, 1'b0, DST_NONE};
			5'd1:  op = '{OPND_M4,  OPND_M4, 1'b0, 1'b1, DST_C00};
			5'd2:  op = '{OPND_M2,  OPND_M4, 1'b1, 1'b0, DST_NONE};
			5'd3:  op = '{OPND_M1,  OPND_M5, 1'b0, 1'b1, DST_C01};
			5'd4:  op = '{OPND_M1,  OPND_M4, 1'b1, 1'b0, DST_NONE};
			5'd5:  op = '{OPND_M3,  OPND_M2, 1'b0, 1'b1, DST_C02};
			5'd6:  op = '{OPND_M0,  OPND_M5, 1'b1, 1'b0, DST_NONE};
			5'd7:  op = '{OPND_M2,  OPND_M2, 1'b0, 1'b1, DST_C11};
			5'd8:  op = '{OPND_M1,  OPND_M2, 1'b1, 1'b0, DST_NONE};
			5'd9:  op = '{OPND_M0,  OPND_M4, 1'b0, 1'b1, DST_C12};
			5'd10: op = '{OPND_M0,  OPND_M3, 1'b1, 1'b0, DST_NONE};
			5'd11: op = '{OPND_M1,  OPND_M1, 1'b0, 1'b1, DST_C22};
			5'd12: op = '{OPND_C00, OPND_M0, 1'b1, 1'b0, DST_NONE};
			5'd13: op = '{OPND_C01, OPND_M1, 1'b0, 1'b0, DST_NONE};
			5'd14: op = '{OPND_C02, OPND_M2, 1'b0, 1'b0, DST_DET};
			5'd15: op = '{OPND_C00, OPND_S0, 1'b1, 1'b1, DST_NONE};
			5'd16: op = '{OPND_C01, OPND_S1, 1'b0, 1'b1, DST_NONE};
			5'd17: op = '{OPND_C02, OPND_S2, 1'b0, 1'b1, DST_NUM};
			5'd18: op = '{OPND_C01, OPND_S0, 1'b1, 1'b1, DST_NONE};
			5'd19: op = '{OPND_C11, OPND_S1, 1'b0, 1'b1, DST_NONE};
			5'd20: op = '{OPND_C12, OPND_S2, 1'b0, 1'b1, DST_NUM};
			5'd21: op = '{OPND_C02, OPND_S0, 1'b1, 1'b1, DST_NONE};
			5'd22: op = '{OPND_C12, OPND_S1, 1'b0, 1'b1, DST_NONE};
			5'd23: op = '{OPND_C22, OPND_S2, 1'b0, 1'b1, DST_NUM};
			5'd24: op = '{OPND_CA,  OPND_CA, 1'b1, 1'b0, DST_NONE};
			5'd25: op = '{OPND_CB,  OPND_CB, 1'b0, 1'b0, DST_NONE};
			5'd26: op = '{OPND_CC,  OPND_CC, 1'b0, 1'b0, DST_SUMSQ};
			default: op = '{OPND_M0, OPND_M0, 1'b0, 1'b0, DST_NONE};
		endcase
		return op;
	endfunction

endpackage

### rtl/least_squares_plane_fit_unit.sv
// Least-squares plane fit: point accumulation and iterative solve on one shared adder.
//
// Usage: drive a probe point on point and pulse start while busy is low; the
// point is taken at that edge and busy rises. In accumulation the single
// 24x24 multiplier forms the six coordinate products one per cycle. Points
// beyond MAX_POINTS are ignored but a last_point flag still triggers the
// solve.
// On a point marked last_point the solve runs on one 192-bit add/subtract
// unit: 27 shift-add multiplies, three 192-step restoring divisions and a
// 64-step square root; a singular matrix ends the solve after the
// determinant check. Then done pulses for one cycle with
// the result on result, busy is already low and the sums are cleared.
// Points not marked last give no result.
// The receiver cannot stall: the result must be taken in its done cycle.
// Reset (arst_n low) clears the sums, the point count and the sequencer.
module least_squares_plane_fit_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  lspf_pkg::point_t  point,
	output logic            busy,
	output logic            done,
	output lspf_pkg::result_t result
);
	import lspf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_ACCUM, S_MAC_LOAD, S_MAC, S_MAC_END, S_DET_ABS, S_DET_LIM,
		S_DIV_INIT, S_DIV, S_DIV_END, S_SQRT_INIT, S_SQRT, S_FINISH
	} state_t;

	state_t                    state_q;
	logic [STEP_W-1:0]         step_q;
	logic [PC_W-1:0]           pc_q;
	logic [1:0]                coef_idx_q;
	logic [PTS_W-1:0]          pts_q;
	logic signed [MOM_W-1:0]   m_q [6];
	logic signed [SUM_W-1:0]   cs_q [3];
	logic                      done_q;
	result_t                   result_q;

	point_t                    point_q;
	logic signed [PROD_W-1:0]  prod_s1;
	logic [WIDE_W-1:0]         acc_q;
	logic [WIDE_W-1:0]         mul_a_q;
	logic [COEF_W-1:0]         mul_b_q;
	logic signed [CO_W-1:0]    cof_q [6];
	logic [WIDE_W-1:0]         det_q;
	logic [WIDE_W-1:0]         det_abs_q;
	logic [WIDE_W-1:0]         rem_q;
	logic [WIDE_W-1:0]         div_n_q;
	logic [COEF_W-1:0]         quo_q;
	logic                      big_q;
	logic                      neg_q;
	logic signed [COEF_W-1:0]  coef_q [3];

	mac_op_t                   cur_op;
	logic [WIDE_W-1:0]         opa;
	logic [WIDE_W-1:0]         opb;
	logic                      sub;
	logic [WIDE_W-1:0]         sum;
	logic                      take;
	logic [WIDE_W-1:0]         remsh_div;
	logic [WIDE_W-1:0]         remsh_sq;
	logic signed [COORD_W-1:0] fa;
	logic signed [COORD_W-1:0] fb;
	logic [2:0]                mom_idx;
	logic                      room;

	// Sign-extended value of a microprogram operand
	function automatic logic [WIDE_W-1:0] opnd_val(input opnd_t sel);
		logic [WIDE_W-1:0] v;
		v = '0;
		case (sel)
			OPND_M0:  v = WIDE_W'(m_q[0]);
			OPND_M1:  v = WIDE_W'(m_q[1]);
			OPND_M2:  v = WIDE_W'(m_q[2]);
			OPND_M3:  v = WIDE_W'(m_q[3]);
			OPND_M4:  v = WIDE_W'(m_q[4]);
			OPND_M5:  v = WIDE_W'(m_q[5]);
			OPND_C00: v = WIDE_W'(cof_q[0]);
			OPND_C01: v = WIDE_W'(cof_q[1]);
			OPND_C02: v = WIDE_W'(cof_q[2]);
			OPND_C11: v = WIDE_W'(cof_q[3]);
			OPND_C12: v = WIDE_W'(cof_q[4]);
			OPND_C22: v = WIDE_W'(cof_q[5]);
			OPND_S0:  v = WIDE_W'(cs_q[0]);
			OPND_S1:  v = WIDE_W'(cs_q[1]);
			OPND_S2:  v = WIDE_W'(cs_q[2]);
			OPND_CA:  v = WIDE_W'(coef_q[0]);
			OPND_CB:  v = WIDE_W'(coef_q[1]);
			OPND_CC:  v = WIDE_W'(coef_q[2]);
			default:  v = '0;
		endcase
		return v;
	endfunction

	assign cur_op    = prog_op(pc_q);
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign room      = (pts_q < PTS_W'(MAX_POINTS));
	assign mom_idx   = step_q[2:0] - 3'd1;
	assign remsh_div = {rem_q[WIDE_W-2:0], div_n_q[WIDE_W-1]};
	assign remsh_sq  = {rem_q[WIDE_W-3:0], div_n_q[SQ_W-1:SQ_W-2]};

	// Select the operands of the shared add/subtract unit
	always_comb begin
		opa = acc_q;
		opb = mul_a_q;
		sub = 1'b0;
		case (state_q)
			S_MAC: begin
				sub = cur_op.neg ^ (step_q == STEP_W'(MUL_STEPS - 1));
			end
			S_DET_ABS: begin
				opa = '0;
				opb = det_q;
				sub = 1'b1;
			end
			S_DET_LIM: begin
				opa = det_abs_q;
				opb = DET_LIMIT;
				sub = 1'b1;
			end
			S_DIV_INIT: begin
				opa = '0;
				opb = acc_q;
				sub = 1'b1;
			end
			S_DIV: begin
				opa = remsh_div;
				opb = det_abs_q;
				sub = 1'b1;
			end
			S_DIV_END: begin
				opa = '0;
				opb = WIDE_W'(quo_q);
				sub = 1'b1;
			end
			S_SQRT: begin
				opa = remsh_sq;
				opb = WIDE_W'({quo_q, 2'b01});
				sub = 1'b1;
			end
			default: begin
				opa = acc_q;
				opb = mul_a_q;
				sub = 1'b0;
			end
		endcase
		sum  = opa + (sub ? ~opb : opb) + WIDE_W'(sub);
		take = ~sum[WIDE_W-1];
	end

	// Pick the coordinate pair for this accumulation step
	always_comb begin
		fa = point_q.x_pos;
		fb = point_q.x_pos;
		case (step_q[2:0])
			3'd1: begin fa = point_q.x_pos; fb = point_q.y_pos; end
			3'd2: begin fa = point_q.x_pos; fb = point_q.z_pos; end
			3'd3: begin fa = point_q.y_pos; fb = point_q.y_pos; end
			3'd4: begin fa = point_q.y_pos; fb = point_q.z_pos; end
			3'd5: begin fa = point_q.z_pos; fb = point_q.z_pos; end
			default: begin fa = point_q.x_pos; fb = point_q.x_pos; end
		endcase
	end

	// Sequencer, sums and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= '0;
			pc_q       <= '0;
			coef_idx_q <= '0;
			pts_q      <= '0;
			done_q     <= 1'b0;
			result_q   <= '0;
			for (int i = 0; i < 6; i++) m_q[i] <= '0;
			for (int i = 0; i < 3; i++) cs_q[i] <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_ACCUM;
						step_q  <= '0;
					end
				end
				S_ACCUM: begin
					step_q <= step_q + 1'b1;
					if (room && step_q == '0) begin
						cs_q[0] <= cs_q[0] + SUM_W'($signed(point_q.x_pos));
						cs_q[1] <= cs_q[1] + SUM_W'($signed(point_q.y_pos));
						cs_q[2] <= cs_q[2] + SUM_W'($signed(point_q.z_pos));
					end
					if (room && step_q != '0) begin
						m_q[mom_idx] <= m_q[mom_idx] + MOM_W'(prod_s1);
					end
					if (step_q == STEP_W'(ACC_STEPS - 1)) begin
						if (room) pts_q <= pts_q + 1'b1;
						if (point_q.last_point) begin
							pc_q    <= '0;
							state_q <= S_MAC_LOAD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_MAC_LOAD: begin
					step_q  <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(MUL_STEPS - 1)) state_q <= S_MAC_END;
				end
				S_MAC_END: begin
					case (cur_op.dst)
						DST_DET:   state_q <= S_DET_ABS;
						DST_NUM:   state_q <= S_DIV_INIT;
						DST_SUMSQ: state_q <= S_SQRT_INIT;
						default: begin
							pc_q    <= pc_q + 1'b1;
							state_q <= S_MAC_LOAD;
						end
					endcase
				end
				S_DET_ABS: begin
					state_q <= S_DET_LIM;
				end
				S_DET_LIM: begin
					coef_idx_q <= '0;
					if (sum[WIDE_W-1]) begin
						// Singular: report zeros and drop the sums
						result_q <= '{'0, '0, '0, '0, 1'b1};
						done_q   <= 1'b1;
						pts_q    <= '0;
						for (int i = 0; i < 6; i++) m_q[i] <= '0;
						for (int i = 0; i < 3; i++) cs_q[i] <= '0;
						state_q  <= S_IDLE;
					end else begin
						pc_q    <= pc_q + 1'b1;
						state_q <= S_MAC_LOAD;
					end
				end
				S_DIV_INIT: begin
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) state_q <= S_DIV_END;
				end
				S_DIV_END: begin
					coef_idx_q <= coef_idx_q + 1'b1;
					pc_q       <= pc_q + 1'b1;
					state_q    <= S_MAC_LOAD;
				end
				S_SQRT_INIT: begin
					step_q  <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SQRT_STEPS - 1)) state_q <= S_FINISH;
				end
				S_FINISH: begin
					result_q.coef_a     <= coef_q[0];
					result_q.coef_b     <= coef_q[1];
					result_q.coef_c     <= coef_q[2];
					result_q.plane_norm <= quo_q[COEF_W-1] ? {NORM_W{1'b1}}
						: quo_q[NORM_W-1:0];
					result_q.singular   <= 1'b0;
					done_q  <= 1'b1;
					pts_q   <= '0;
					for (int i = 0; i < 6; i++) m_q[i] <= '0;
					for (int i = 0; i < 3; i++) cs_q[i] <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) point_q <= point;
			end
			S_ACCUM: begin
				prod_s1 <= fa * fb;
			end
			S_MAC_LOAD: begin
				mul_a_q <= opnd_val(cur_op.a_sel);
				mul_b_q <= COEF_W'(opnd_val(cur_op.b_sel));
				if (cur_op.clr) acc_q <= '0;
			end
			S_MAC: begin
				// Shift-add over the multiplier bits, top bit weighs negative
				if (mul_b_q[0]) acc_q <= sum;
				mul_a_q <= mul_a_q << 1;
				mul_b_q <= mul_b_q >> 1;
			end
			S_MAC_END: begin
				case (cur_op.dst)
					DST_C00: cof_q[0] <= acc_q[CO_W-1:0];
					DST_C01: cof_q[1] <= acc_q[CO_W-1:0];
					DST_C02: cof_q[2] <= acc_q[CO_W-1:0];
					DST_C11: cof_q[3] <= acc_q[CO_W-1:0];
					DST_C12: cof_q[4] <= acc_q[CO_W-1:0];
					DST_C22: cof_q[5] <= acc_q[CO_W-1:0];
					DST_DET: det_q    <= acc_q;
					default: ;
				endcase
			end
			S_DET_ABS: begin
				det_abs_q <= det_q[WIDE_W-1] ? sum : det_q;
			end
			S_DIV_INIT: begin
				neg_q   <= acc_q[WIDE_W-1] ^ det_q[WIDE_W-1];
				div_n_q <= (acc_q[WIDE_W-1] ? sum : acc_q) << FRAC_SHIFT;
				rem_q   <= '0;
				quo_q   <= '0;
				big_q   <= 1'b0;
			end
			S_DIV: begin
				rem_q   <= take ? sum : remsh_div;
				quo_q   <= {quo_q[COEF_W-2:0], take};
				big_q   <= big_q | quo_q[COEF_W-1];
				div_n_q <= div_n_q << 1;
			end
			S_DIV_END: begin
				// Apply sign and saturate to the coefficient range
				if (big_q || quo_q[COEF_W-1]) begin
					coef_q[coef_idx_q] <= neg_q ? COEF_MIN : COEF_MAX;
				end else begin
					coef_q[coef_idx_q] <= neg_q ? sum[COEF_W-1:0] : quo_q;
				end
			end
			S_SQRT_INIT: begin
				div_n_q <= acc_q;
				rem_q   <= '0;
				quo_q   <= '0;
			end
			S_SQRT: begin
				rem_q   <= take ? sum : remsh_sq;
				quo_q   <= {quo_q[COEF_W-2:0], take};
				div_n_q <= div_n_q << 2;
			end
			default: ;
		endcase
	end

	// A result transaction leaves the block idle
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result issued while busy");

	// A singular result carries zero coefficients and norm
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.singular) |-> (result.coef_a == '0 && result.coef_b == '0
		&& result.coef_c == '0 && result.plane_norm == '0))
		else $error("singular result with nonzero fields");

	// Accepting a point makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("point accepted without going busy");

	// The result strobe lasts one cycle
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe held");

	// The point count never passes its limit
	assert property (@(posedge clk) disable iff (!arst_n) pts_q <= PTS_W'(MAX_POINTS))
		else $error("point count overflow");

endmodule

### bench/least_squares_plane_fit_unit_tb.sv
// Self-checking testbench for the least-squares plane fit unit.
module least_squares_plane_fit_unit_tb;
	import lspf_pkg::*;

	typedef logic signed [255:0] wide_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	point_t  point;
	logic    busy;
	logic    done;
	result_t result;

	least_squares_plane_fit_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .point(point),
		.busy(busy), .done(done), .result(result)
	);

	// Fit state mirrored by the predictor
	logic [MOM_W-1:0] mom_acc [6];
	logic [SUM_W-1:0] coord_acc [3];
	int               pts_held;

	result_t fit_queue [$];
	int      mismatches;
	int      sent_points;
	int      fits_seen;
	int      singular_seen;
	int      saturated_seen;
	bit      quiet_sender;

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	function automatic wide_t sext53(logic [MOM_W-1:0] v);
		return {{(256-MOM_W){v[MOM_W-1]}}, v};
	endfunction

	function automatic wide_t sext31(logic [SUM_W-1:0] v);
		return {{(256-SUM_W){v[SUM_W-1]}}, v};
	endfunction

	function automatic wide_t abs_w(wide_t v);
		return v[255] ? -v : v;
	endfunction

	// Truncated num * 2^48 / det, saturated to 64 bits
	function automatic logic signed [63:0] coef_div(wide_t num, wide_t den);
		logic        neg;
		logic [255:0] q;
		neg = num[255] ^ den[255];
		q = abs_w(num <<< FRAC_SHIFT) / abs_w(den);
		if (q[255:63] != '0)
			return neg ? COEF_MIN : COEF_MAX;
		return neg ? -$signed({1'b0, q[62:0]}) : $signed({1'b0, q[62:0]});
	endfunction

	function automatic logic [NORM_W-1:0] coef_norm(logic signed [63:0] a,
		logic signed [63:0] b, logic signed [63:0] c);
		wide_t       s;
		wide_t       t;
		logic [63:0] r;
		s = wide_t'(a) * wide_t'(a) + wide_t'(b) * wide_t'(b) + wide_t'(c) * wide_t'(c);
		r = '0;
		for (int k = 63; k >= 0; k--) begin
			t = {192'd0, r | (64'd1 << k)};
			if (t * t <= s)
				r = r | (64'd1 << k);
		end
		return r[63] ? {NORM_W{1'b1}} : r[NORM_W-1:0];
	endfunction

	function automatic void clear_fit();
		for (int k = 0; k < 6; k++) mom_acc[k] = '0;
		for (int k = 0; k < 3; k++) coord_acc[k] = '0;
		pts_held = 0;
	endfunction

	// Accumulate one point; on a last point, solve and return the fit
	function automatic bit predict_fit(point_t p, output result_t r);
		logic signed [63:0] c [3];
		wide_t m [6];
		wide_t y [3];
		wide_t k00, k01, k02, k11, k12, k22, det;
		logic signed [63:0] ca, cb, cc;
		c[0] = p.x_pos;
		c[1] = p.y_pos;
		c[2] = p.z_pos;
		r = '0;
		if (pts_held < MAX_POINTS) begin
			mom_acc[0] = mom_acc[0] + MOM_W'(c[0] * c[0]);
			mom_acc[1] = mom_acc[1] + MOM_W'(c[0] * c[1]);
			mom_acc[2] = mom_acc[2] + MOM_W'(c[0] * c[2]);
			mom_acc[3] = mom_acc[3] + MOM_W'(c[1] * c[1]);
			mom_acc[4] = mom_acc[4] + MOM_W'(c[1] * c[2]);
			mom_acc[5] = mom_acc[5] + MOM_W'(c[2] * c[2]);
			for (int k = 0; k < 3; k++) coord_acc[k] = coord_acc[k] + SUM_W'(c[k]);
			pts_held++;
		end
		if (!p.last_point)
			return 1'b0;
		for (int k = 0; k < 6; k++) m[k] = sext53(mom_acc[k]);
		for (int k = 0; k < 3; k++) y[k] = -sext31(coord_acc[k]);
		k00 = m[3] * m[5] - m[4] * m[4];
		k01 = m[2] * m[4] - m[1] * m[5];
		k02 = m[1] * m[4] - m[3] * m[2];
		k11 = m[0] * m[5] - m[2] * m[2];
		k12 = m[1] * m[2] - m[0] * m[4];
		k22 = m[0] * m[3] - m[1] * m[1];
		det = m[0] * k00 + m[1] * k01 + m[2] * k02;
		clear_fit();
		if (abs_w(det) < wide_t'(DET_LIMIT)) begin
			r.singular = 1'b1;
			return 1'b1;
		end
		ca = coef_div(k00 * y[0] + k01 * y[1] + k02 * y[2], det);
		cb = coef_div(k01 * y[0] + k11 * y[1] + k12 * y[2], det);
		cc = coef_div(k02 * y[0] + k12 * y[1] + k22 * y[2], det);
		r.coef_a = ca;
		r.coef_b = cb;
		r.coef_c = cc;
		r.plane_norm = coef_norm(ca, cb, cc);
		return 1'b1;
	endfunction

	// Check each fit against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (fit_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected fit result %h", result);
			end else begin
				want = fit_queue.pop_front();
				fits_seen++;
				if (want.singular) singular_seen++;
				if (want.coef_a == COEF_MAX || want.coef_a == COEF_MIN ||
					want.coef_b == COEF_MAX || want.coef_b == COEF_MIN ||
					want.coef_c == COEF_MAX || want.coef_c == COEF_MIN)
					saturated_seen++;
				if (result.coef_a !== want.coef_a || result.coef_b !== want.coef_b ||
					result.coef_c !== want.coef_c ||
					result.plane_norm !== want.plane_norm ||
					result.singular !== want.singular) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("fit %0d mismatch: expected a=%h b=%h c=%h n=%h s=%b",
							fits_seen, want.coef_a, want.coef_b, want.coef_c,
							want.plane_norm, want.singular);
						$display("                 actual a=%h b=%h c=%h n=%h s=%b",
							result.coef_a, result.coef_b, result.coef_c,
							result.plane_norm, result.singular);
					end
				end
			end
		end
	end

	// Hold start low for a random burst now and then
	task automatic sender_gap();
		if (!quiet_sender && $urandom_range(3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Offer one point and wait for its transaction
	task automatic send_point(logic signed [23:0] x, logic signed [23:0] y,
		logic signed [23:0] z, logic last);
		point_t  p;
		result_t r;
		p = '{x, y, z, last};
		sender_gap();
		start <= 1'b1;
		point <= p;
		do @(posedge clk); while (busy);
		if (predict_fit(p, r))
			fit_queue.push_back(r);
		sent_points++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (fit_queue.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_coord(int mode);
		case (mode)
			0: return 24'($signed($urandom_range(0, 2000)) - 1000);
			1: return 24'($urandom);
			default: return 24'($signed($urandom_range(0, 200000)) - 100000);
		endcase
	endfunction

	task automatic test_extremes();
		send_point(24'h7FFFFF, 24'h000000, 24'h000000, 1'b0);
		send_point(24'h000000, 24'h7FFFFF, 24'h000000, 1'b0);
		send_point(24'h000000, 24'h000000, 24'h7FFFFF, 1'b1);
		send_point(24'h800000, 24'h800000, 24'h800000, 1'b0);
		send_point(24'h800000, 24'h7FFFFF, 24'h800000, 1'b0);
		send_point(24'h7FFFFF, 24'h800000, 24'h800000, 1'b0);
		send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
		send_point(24'h001000, 24'h002000, 24'h000100, 1'b0);
		send_point(24'h003000, 24'hFFF000, 24'h000120, 1'b0);
		send_point(24'hFFE000, 24'h001000, 24'h0000F0, 1'b1);
	endtask

	task automatic test_singular();
		// lone point, two points, collinear set, tiny coordinates
		send_point(24'h012345, 24'h054321, 24'h000777, 1'b1);
		send_point(24'h010000, 24'h020000, 24'h000100, 1'b0);
		send_point(24'hF00000, 24'h030000, 24'h000200, 1'b1);
		send_point(24'h000100, 24'h000200, 24'h000300, 1'b0);
		send_point(24'h000200, 24'h000400, 24'h000600, 1'b0);
		send_point(24'h000300, 24'h000600, 24'h000900, 1'b1);
		send_point(24'h000001, 24'h000000, 24'h000000, 1'b0);
		send_point(24'h000000, 24'h000001, 24'h000000, 1'b0);
		send_point(24'h000000, 24'h000000, 24'h000001, 1'b1);
	endtask

	task automatic test_point_overflow();
		// more points than the unit holds: extras are dropped
		for (int k = 0; k < 7; k++)
			send_point(rand_coord(2), rand_coord(2), rand_coord(0), k == 6);
		wait_drained();
	endtask

	task automatic test_random_sets(int n_points);
		int left;
		int len;
		int mode;
		int slope_x;
		int slope_y;
		logic signed [23:0] x, y, z;
		left = n_points;
		while (left > 0) begin
			len = $urandom_range(1, 8);
			if (len > left) len = left;
			mode = $urandom_range(0, 3);
			slope_x = $signed($urandom_range(0, 64)) - 32;
			slope_y = $signed($urandom_range(0, 64)) - 32;
			if (left < 200) quiet_sender = 1'b1;
			for (int k = 0; k < len; k++) begin
				x = rand_coord(mode == 3 ? 2 : mode);
				y = rand_coord(mode == 3 ? 2 : mode);
				// near-plane sets resemble a real bed; others are noise
				z = (mode == 3) ? 24'(((x * slope_x + y * slope_y) >>> 8)
					+ $signed($urandom_range(0, 64)) - 32) : rand_coord($urandom_range(0, 2));
				send_point(x, y, z, k == len - 1);
			end
			left -= len;
			if ($urandom_range(15) == 0) wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		point = '0;
		mismatches = 0;
		sent_points = 0;
		fits_seen = 0;
		singular_seen = 0;
		saturated_seen = 0;
		quiet_sender = 1'b0;
		clear_fit();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_singular();
		test_point_overflow();
		test_random_sets(1820);
		wait_drained();
		repeat (50) @(posedge clk);
		$display("Sent %0d points and checked %0d fits (%0d singular, %0d saturated).",
			sent_points, fits_seen, singular_seen, saturated_seen);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Guard against a hung unit
	initial begin
		#250000000;
		$display("Timed out with %0d fits outstanding.", fit_queue.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### sim.f
rtl/lspf_pkg.sv
rtl/least_squares_plane_fit_unit.sv
bench/least_squares_plane_fit_unit_tb.sv
